>>> src/sm4_pkg.sv
// Shared definitions for the SM4 CBC block cipher: S-box, FK/CK constants,
// register map and sequencer states. No dependencies.
package sm4_pkg;

    localparam int RK_DEPTH = 32;
    localparam int RK_AW    = 5;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;

    typedef enum logic [2:0] {
        ST_KINIT,
        ST_KEY,
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } state_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // CK word i: byte j from the top is (4*i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
        logic [31:0] w;
        logic [7:0]  b;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            b = {1'b0, i, 2'b00} + 8'(j);
            w[31-8*j -: 8] = 8'(b * 8'd7);
        end
        return w;
    endfunction

endpackage

>>> src/sm4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sm4_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/sm4_round.sv
// Shared SM4 round unit: S-box layer plus the cipher L or key schedule L'.
// Depends on sm4_pkg.
module sm4_round (
    input  logic        key_sched,
    input  logic [31:0] x0,
    input  logic [31:0] x1,
    input  logic [31:0] x2,
    input  logic [31:0] x3,
    input  logic [31:0] rk,
    output logic [31:0] nx
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] l_out;

    assign a = x1 ^ x2 ^ x3 ^ rk;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            b[8*j +: 8] = sm4_pkg::SBOX[a[8*j +: 8]];
        end
    end

    always_comb begin
        if (key_sched) begin
            l_out = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
        end else begin
            l_out = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                      ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
        end
    end

    assign nx = x0 ^ l_out;

endmodule

>>> src/sm4_cbc_block_cipher.sv
// Top level of the SM4-128 CBC block cipher: APB register port, stream ports,
// sequencer, round key RAM. Depends on sm4_pkg, sm4_round, sm4_ram.
//
// One shared round unit does one SM4 round per cycle, for the key schedule and
// for the cipher alike. An input request is taken in the idle state, runs 32
// rounds and is then written to the output register from the finish state; a
// new request is taken only after the previous one has left the finish state.
// A finished result waits in the output register while the next request is
// taken; a result is only held back if the previous one is still untaken.
// After reset and after each key write the round keys are re-expanded into the
// round key RAM, with s_tready low meanwhile. Registers are 64 bits at byte
// addresses 0 (key high), 8 (key low), 16 (IV high), 24 (IV low), 32 (decrypt
// mode, bit 0). IV and mode writes reload the chain.
module sm4_cbc_block_cipher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] block_high, [127:64] block_low
    input  logic         s_tlast,   // last_block
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] result_high, [127:64] result_low
    output logic         m_tlast    // result_last
);

    sm4_pkg::state_t state_reg, state_next;

    logic [63:0]  key_hi_reg, key_hi_next, key_lo_reg, key_lo_next;
    logic [63:0]  iv_hi_reg, iv_hi_next, iv_lo_reg, iv_lo_next;
    logic         mode_reg, mode_next;
    logic [63:0]  chain_hi_reg, chain_hi_next, chain_lo_reg, chain_lo_next;
    logic [63:0]  blk_hi_reg, blk_hi_next, blk_lo_reg, blk_lo_next;
    logic         last_reg, last_next;
    logic [31:0]  w0_reg, w0_next, w1_reg, w1_next, w2_reg, w2_next, w3_reg, w3_next;
    logic [sm4_pkg::RK_AW-1:0] rnd_reg, rnd_next;
    logic [127:0] out_data_reg, out_data_next;
    logic         out_last_reg, out_last_next;
    logic         out_valid_reg, out_valid_next;

    logic         cfg_wr;
    logic [2:0]   cfg_idx;
    logic         key_sched;
    logic [31:0]  rk;
    logic [31:0]  nx;
    logic [31:0]  ram_rdata;
    logic         ram_we;
    logic [sm4_pkg::RK_AW-1:0] rd_idx;
    logic [sm4_pkg::RK_AW-1:0] rd_addr;
    logic [63:0]  res_hi, res_lo;
    logic         out_free;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = paddr[5:3];
    assign s_tready = (state_reg == sm4_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        case (cfg_idx)
            sm4_pkg::REG_KEY_HIGH: prdata = key_hi_reg;
            sm4_pkg::REG_KEY_LOW:  prdata = key_lo_reg;
            sm4_pkg::REG_IV_HIGH:  prdata = iv_hi_reg;
            sm4_pkg::REG_IV_LOW:   prdata = iv_lo_reg;
            sm4_pkg::REG_MODE:     prdata = {63'd0, mode_reg};
            default:               prdata = '0;
        endcase
    end

    assign key_sched = (state_reg == sm4_pkg::ST_KEY);
    assign rk        = key_sched ? sm4_pkg::ck_word(rnd_reg) : ram_rdata;

    sm4_round u_round (
        .key_sched (key_sched),
        .x0        (w0_reg),
        .x1        (w1_reg),
        .x2        (w2_reg),
        .x3        (w3_reg),
        .rk        (rk),
        .nx        (nx)
    );

    // key for round i+1 is fetched while round i runs
    assign rd_idx  = (state_reg == sm4_pkg::ST_ROUND) ? rnd_reg + 1'b1 : '0;
    assign rd_addr = mode_reg ? ~rd_idx : rd_idx;

    sm4_ram #(
        .WIDTH (32),
        .DEPTH (sm4_pkg::RK_DEPTH)
    ) u_rk_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (rnd_reg),
        .wdata (nx),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign res_hi   = {w3_reg, w2_reg} ^ (mode_reg ? chain_hi_reg : 64'd0);
    assign res_lo   = {w1_reg, w0_reg} ^ (mode_reg ? chain_lo_reg : 64'd0);
    assign out_free = ~out_valid_reg | m_tready;

    always_comb begin
        state_next     = state_reg;
        key_hi_next    = key_hi_reg;
        key_lo_next    = key_lo_reg;
        iv_hi_next     = iv_hi_reg;
        iv_lo_next     = iv_lo_reg;
        mode_next      = mode_reg;
        chain_hi_next  = chain_hi_reg;
        chain_lo_next  = chain_lo_reg;
        blk_hi_next    = blk_hi_reg;
        blk_lo_next    = blk_lo_reg;
        last_next      = last_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        rnd_next       = rnd_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sm4_pkg::ST_KINIT: begin
                w0_next    = key_hi_reg[63:32] ^ sm4_pkg::FK0;
                w1_next    = key_hi_reg[31:0]  ^ sm4_pkg::FK1;
                w2_next    = key_lo_reg[63:32] ^ sm4_pkg::FK2;
                w3_next    = key_lo_reg[31:0]  ^ sm4_pkg::FK3;
                rnd_next   = '0;
                state_next = sm4_pkg::ST_KEY;
            end
            sm4_pkg::ST_KEY: begin
                ram_we   = 1'b1;
                w0_next  = w1_reg;
                w1_next  = w2_reg;
                w2_next  = w3_reg;
                w3_next  = nx;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == '1) begin
                    state_next = sm4_pkg::ST_IDLE;
                end
            end
            sm4_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    blk_hi_next = s_tdata[63:0];
                    blk_lo_next = s_tdata[127:64];
                    last_next   = s_tlast;
                    if (mode_reg) begin
                        {w0_next, w1_next} = s_tdata[63:0];
                        {w2_next, w3_next} = s_tdata[127:64];
                    end else begin
                        {w0_next, w1_next} = s_tdata[63:0]   ^ chain_hi_reg;
                        {w2_next, w3_next} = s_tdata[127:64] ^ chain_lo_reg;
                    end
                    rnd_next   = '0;
                    state_next = sm4_pkg::ST_ROUND;
                end
            end
            sm4_pkg::ST_ROUND: begin
                w0_next  = w1_reg;
                w1_next  = w2_reg;
                w2_next  = w3_reg;
                w3_next  = nx;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == '1) begin
                    state_next = sm4_pkg::ST_FINISH;
                end
            end
            sm4_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_data_next  = {res_lo, res_hi};
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                    if (last_reg) begin
                        chain_hi_next = iv_hi_reg;
                        chain_lo_next = iv_lo_reg;
                    end else if (mode_reg) begin
                        chain_hi_next = blk_hi_reg;
                        chain_lo_next = blk_lo_reg;
                    end else begin
                        chain_hi_next = res_hi;
                        chain_lo_next = res_lo;
                    end
                    state_next = sm4_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sm4_pkg::ST_KINIT;
            end
        endcase

        if (cfg_wr) begin
            case (cfg_idx)
                sm4_pkg::REG_KEY_HIGH: begin
                    key_hi_next = pwdata;
                    state_next  = sm4_pkg::ST_KINIT;
                end
                sm4_pkg::REG_KEY_LOW: begin
                    key_lo_next = pwdata;
                    state_next  = sm4_pkg::ST_KINIT;
                end
                sm4_pkg::REG_IV_HIGH: begin
                    iv_hi_next    = pwdata;
                    chain_hi_next = pwdata;
                    chain_lo_next = iv_lo_reg;
                end
                sm4_pkg::REG_IV_LOW: begin
                    iv_lo_next    = pwdata;
                    chain_hi_next = iv_hi_reg;
                    chain_lo_next = pwdata;
                end
                sm4_pkg::REG_MODE: begin
                    mode_next     = pwdata[0];
                    chain_hi_next = iv_hi_reg;
                    chain_lo_next = iv_lo_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sm4_pkg::ST_KINIT;
            key_hi_reg    <= '0;
            key_lo_reg    <= '0;
            iv_hi_reg     <= '0;
            iv_lo_reg     <= '0;
            mode_reg      <= 1'b0;
            chain_hi_reg  <= '0;
            chain_lo_reg  <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_hi_reg    <= key_hi_next;
            key_lo_reg    <= key_lo_next;
            iv_hi_reg     <= iv_hi_next;
            iv_lo_reg     <= iv_lo_next;
            mode_reg      <= mode_next;
            chain_hi_reg  <= chain_hi_next;
            chain_lo_reg  <= chain_lo_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_hi_reg   <= blk_hi_next;
        blk_lo_reg   <= blk_lo_next;
        last_reg     <= last_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        w3_reg       <= w3_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule
